@@ sv/psdbg_pkg.sv @@
// shared constants and register codes for the power source debounce / battery gauge
// no dependencies
package psdbg_pkg;

  localparam int RATIO_W    = 12;
  localparam int THRESH_W   = 12;
  localparam int DEB_W      = 16;
  localparam int MV_W       = 16;
  localparam int PCT_W      = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int NUM_W      = 24;
  localparam int DIV_STEPS  = 7;
  localparam int CNT_W      = 4;

  localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;
  localparam logic [MV_W-1:0]  MV_MAX   = 16'hFFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAINS_THRESHOLD = 3'd0,
    REG_DEBOUNCE        = 3'd1,
    REG_DIVIDER_RATIO   = 3'd2,
    REG_BATTERY_EMPTY   = 3'd3,
    REG_BATTERY_FULL    = 3'd4,
    REG_SENSE_MODE      = 3'd5,
    REG_LOW_PERCENT     = 3'd6,
    REG_STATUS_LOW      = 3'd7
  } cfg_reg_t;

endpackage

@@ sv/psdbg_gauge.sv @@
// bit-serial battery scaling and percentage divider
// depends on psdbg_pkg
module psdbg_gauge import psdbg_pkg::*; #(
  parameter int ADC_BITS = 12
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [ADC_BITS-1:0] adc_mv,
  input  logic [RATIO_W-1:0]  ratio,
  input  logic [MV_W-1:0]     empty_mv,
  input  logic [MV_W-1:0]     full_mv,
  output logic                done,
  output logic [MV_W-1:0]     level_mv,
  output logic [PCT_W-1:0]    percent
);

  localparam int P_W = ADC_BITS + RATIO_W + 1;

  typedef enum logic [1:0] {G_IDLE, G_MUL, G_SCALE, G_DIV} gstate_t;

  gstate_t              state;
  logic [P_W-1:0]       prod;
  logic [ADC_BITS-1:0]  adc_r;
  logic [CNT_W-1:0]     cnt;
  logic [NUM_W-1:0]     rem;
  logic [NUM_W-1:0]     dsh;
  logic [PCT_W-1:0]     quo;

  logic [ADC_BITS:0]    sum;
  logic [P_W-1:0]       rounded;
  logic [P_W-1:0]       scaled;
  logic [MV_W-1:0]      mv_sat;
  logic [MV_W-1:0]      diff;
  logic [MV_W-1:0]      span;
  logic [NUM_W-1:0]     num;
  logic [NUM_W-1:0]     den;
  logic                 fits;
  logic [PCT_W-1:0]     quo_next;

  always_comb begin
    sum      = prod[P_W-1:RATIO_W] + (prod[0] ? {1'b0, adc_r} : '0);
    rounded  = {1'b0, prod[P_W-2:0]} + P_W'(128);
    scaled   = rounded >> 8;
    mv_sat   = (scaled > P_W'(MV_MAX)) ? MV_MAX : scaled[MV_W-1:0];
    diff     = mv_sat - empty_mv;
    span     = full_mv - empty_mv;
    num      = (NUM_W'(diff) << 7) + (NUM_W'(diff) << 6) + (NUM_W'(diff) << 3) + NUM_W'(span);
    den      = NUM_W'({span, 1'b0}) << (DIV_STEPS - 1);
    fits     = rem >= dsh;
    quo_next = {quo[PCT_W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= G_IDLE;
      done  <= 1'b0;
    end else begin
      case (state)
        G_IDLE: begin
          done <= 1'b0;
          if (start) begin
            prod  <= P_W'(ratio);
            adc_r <= adc_mv;
            cnt   <= '0;
            state <= G_MUL;
          end
        end
        G_MUL: begin
          done <= 1'b0;
          prod <= {1'b0, sum, prod[RATIO_W-1:1]};
          cnt  <= cnt + 1'b1;
          if (cnt == CNT_W'(RATIO_W - 1)) begin
            state <= G_SCALE;
          end
        end
        G_SCALE: begin
          level_mv <= mv_sat;
          if (mv_sat <= empty_mv) begin
            percent <= '0;
            done    <= 1'b1;
            state   <= G_IDLE;
          end else if (mv_sat >= full_mv) begin
            percent <= PCT_FULL;
            done    <= 1'b1;
            state   <= G_IDLE;
          end else begin
            done  <= 1'b0;
            rem   <= num;
            dsh   <= den;
            quo   <= '0;
            cnt   <= '0;
            state <= G_DIV;
          end
        end
        G_DIV: begin
          if (fits) begin
            rem <= rem - dsh;
          end
          dsh  <= dsh >> 1;
          quo  <= quo_next;
          cnt  <= cnt + 1'b1;
          done <= (cnt == CNT_W'(DIV_STEPS - 1));
          if (cnt == CNT_W'(DIV_STEPS - 1)) begin
            percent <= quo_next;
            state   <= G_IDLE;
          end
        end
        default: begin
          done  <= 1'b0;
          state <= G_IDLE;
        end
      endcase
    end
  end

endmodule

@@ sv/power_source_debounce_battery_gauge.sv @@
// power source debounce with linear battery gauge, top level
// depends on psdbg_pkg and psdbg_gauge
//
// usage: one poll enters on the s_ channel; one result leaves on the m_ channel for every poll.
// the mains sample is thresholded and debounced against the wrapping millisecond timestamp;
// a confirmed change raises changed for that one result.
// the battery sample is scaled by the q8 divider ratio in a bit-serial shift-add multiplier
// (one ratio bit per step) and mapped to percent by a restoring divider
// (one quotient bit per step).
// a new poll is taken only in idle, after the last result entered the result register; in
// status-pin mode or on a failed battery read the poll goes straight to output, else it
// waits on the multiplier and, unless the voltage clamps to 0 or 100 percent, the divider.
// the result register sits between the channels; when the receiver stalls, the block keeps
// computing and holds its next result until the register is free. configuration is written on
// cfg_we/cfg_index/cfg_data; the user must write it only while the block is idle (unchecked).
// reset (rst, synchronous) restores register defaults, clears the filter and gauge values
// and arms first-sample seeding.
module power_source_debounce_battery_gauge import psdbg_pkg::*; #(
  parameter int TIME_WIDTH = 32,
  parameter int ADC_BITS   = 12
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  // mains_mv, mains_ok, battery_adc_mv, battery_ok, status_pin, now_ms
  input  logic [((2*ADC_BITS+3+TIME_WIDTH+7)/8)*8-1:0] s_tdata,
  output logic                     m_tvalid,
  input  logic                     m_tready,
  // changed, on_mains, battery_percent, battery_level_mv, last_mains_mv
  output logic [((2+PCT_W+MV_W+ADC_BITS+7)/8)*8-1:0]   m_tdata,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data
);

  localparam int OUT_W = ((2 + PCT_W + MV_W + ADC_BITS + 7) / 8) * 8;
  localparam int CMP_W = (ADC_BITS > THRESH_W) ? ADC_BITS : THRESH_W;

  typedef enum logic [1:0] {ST_IDLE, ST_GAUGE, ST_OUT} state_t;

  state_t                state;

  logic [THRESH_W-1:0]   mains_threshold_mv;
  logic [DEB_W-1:0]      debounce_ms;
  logic [RATIO_W-1:0]    divider_ratio_q8;
  logic [MV_W-1:0]       battery_empty_mv;
  logic [MV_W-1:0]       battery_full_mv;
  logic                  sense_mode;
  logic [PCT_W-1:0]      low_percent;
  logic                  status_active_low;

  logic                  confirmed_main;
  logic                  candidate_main;
  logic [TIME_WIDTH-1:0] candidate_since;
  logic                  first_sample;
  logic [PCT_W-1:0]      battery_pct;
  logic [MV_W-1:0]       battery_mv;
  logic [ADC_BITS-1:0]   mains_mv;
  logic                  changed;

  logic [ADC_BITS-1:0]   in_mains_mv;
  logic                  in_mains_ok;
  logic [ADC_BITS-1:0]   in_battery_mv;
  logic                  in_battery_ok;
  logic                  in_status_pin;
  logic [TIME_WIDTH-1:0] in_now_ms;

  logic                  accept;
  logic                  inst_main;
  logic [TIME_WIDTH-1:0] elapsed;
  logic                  confirm;
  logic                  is_low;
  logic [PCT_W-1:0]      low_sat;
  logic                  gauge_start;
  logic                  gauge_done;
  logic [MV_W-1:0]       gauge_mv;
  logic [PCT_W-1:0]      gauge_pct;
  logic                  out_free;

  assign in_mains_mv   = s_tdata[ADC_BITS-1:0];
  assign in_mains_ok   = s_tdata[ADC_BITS];
  assign in_battery_mv = s_tdata[2*ADC_BITS:ADC_BITS+1];
  assign in_battery_ok = s_tdata[2*ADC_BITS+1];
  assign in_status_pin = s_tdata[2*ADC_BITS+2];
  assign in_now_ms     = s_tdata[2*ADC_BITS+3 +: TIME_WIDTH];

  assign s_tready    = (state == ST_IDLE);
  assign accept      = s_tvalid && s_tready;
  assign inst_main   = CMP_W'(in_mains_mv) >= CMP_W'(mains_threshold_mv);
  assign elapsed     = in_now_ms - candidate_since;
  assign confirm     = in_mains_ok && !first_sample && (inst_main == candidate_main) &&
                       (candidate_main != confirmed_main) &&
                       (elapsed >= TIME_WIDTH'(debounce_ms));
  assign is_low      = in_status_pin ^ status_active_low;
  assign low_sat     = (low_percent > PCT_FULL) ? PCT_FULL : low_percent;
  assign gauge_start = accept && !sense_mode && in_battery_ok;
  assign out_free    = !m_tvalid || m_tready;

  psdbg_gauge #(
    .ADC_BITS (ADC_BITS)
  ) u_gauge (
    .clk      (clk),
    .rst      (rst),
    .start    (gauge_start),
    .adc_mv   (in_battery_mv),
    .ratio    (divider_ratio_q8),
    .empty_mv (battery_empty_mv),
    .full_mv  (battery_full_mv),
    .done     (gauge_done),
    .level_mv (gauge_mv),
    .percent  (gauge_pct)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      mains_threshold_mv <= 12'd2000;
      debounce_ms        <= 16'd2000;
      divider_ratio_q8   <= 12'd512;
      battery_empty_mv   <= 16'd3300;
      battery_full_mv    <= 16'd4200;
      sense_mode         <= 1'b0;
      low_percent        <= 7'd20;
      status_active_low  <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_MAINS_THRESHOLD: mains_threshold_mv <= cfg_data[THRESH_W-1:0];
        REG_DEBOUNCE:        debounce_ms        <= cfg_data[DEB_W-1:0];
        REG_DIVIDER_RATIO:   divider_ratio_q8   <= cfg_data[RATIO_W-1:0];
        REG_BATTERY_EMPTY:   battery_empty_mv   <= cfg_data[MV_W-1:0];
        REG_BATTERY_FULL:    battery_full_mv    <= cfg_data[MV_W-1:0];
        REG_SENSE_MODE:      sense_mode         <= cfg_data[0];
        REG_LOW_PERCENT:     low_percent        <= cfg_data[PCT_W-1:0];
        REG_STATUS_LOW:      status_active_low  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      m_tvalid        <= 1'b0;
      confirmed_main  <= 1'b0;
      candidate_main  <= 1'b0;
      candidate_since <= '0;
      first_sample    <= 1'b1;
      battery_pct     <= '0;
      battery_mv      <= '0;
      mains_mv        <= '0;
      changed         <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != ST_OUT) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            changed <= confirm;
            if (in_mains_ok) begin
              mains_mv <= in_mains_mv;
              if (first_sample) begin
                candidate_main  <= inst_main;
                candidate_since <= in_now_ms;
                confirmed_main  <= inst_main;
                first_sample    <= 1'b0;
              end else if (inst_main != candidate_main) begin
                candidate_main  <= inst_main;
                candidate_since <= in_now_ms;
              end else if (confirm) begin
                confirmed_main <= candidate_main;
              end
            end
            if (sense_mode) begin
              battery_mv  <= '0;
              battery_pct <= is_low ? low_sat : PCT_FULL;
              state       <= ST_OUT;
            end else if (in_battery_ok) begin
              state <= ST_GAUGE;
            end else begin
              state <= ST_OUT;
            end
          end
        end
        ST_GAUGE: begin
          if (gauge_done) begin
            battery_mv  <= gauge_mv;
            battery_pct <= gauge_pct;
            state       <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            m_tdata  <= OUT_W'({mains_mv, battery_mv, battery_pct, confirmed_main, changed});
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
